// ----- design/dbp_pkg.sv -----
package dbp_pkg;

    localparam int DIGITS_DEF   = 96;
    localparam int GROUP_DIGITS = 16;
    localparam int EXP_BITS     = 31;

    localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

    function automatic logic [3:0] dec_div10(input logic [6:0] t);
        logic [16:0] m;
        m = 17'(t) * 17'd103;
        return m[13:10];
    endfunction

endpackage

// ----- design/dbp_ram.sv -----
module dbp_ram #(
    parameter int W     = 4,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/decimal_bignum_power.sv -----
// Channel  | Handshake              | Payload
// request  | i_valid / o_ready      | i_base, i_exponent
// result   | o_valid / i_ready      | o_digit_group, o_group_index, o_digit_count,
//          |                        | o_overflow, o_last_group
// Each request is worked by the single digit multiply-accumulate unit stepping the
// product memory once per digit pair; rows with a zero multiplier digit are skipped.
// Leading zero digits are then scanned, and each result group is gathered digit by
// digit. Reset is synchronous and needs no clearing pass.
// o_ready is high only while idle; a stalled result holds the block.
module decimal_bignum_power #(
    parameter int DIGITS = dbp_pkg::DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [30:0] i_base,
    input  logic [30:0] i_exponent,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digit_group,
    output logic [2:0]  o_group_index,
    output logic [6:0]  o_digit_count,
    output logic        o_overflow,
    output logic        o_last_group
);

    localparam int AW      = $clog2(DIGITS);
    localparam int PW      = $clog2(2 * DIGITS);
    localparam int CW      = $clog2(DIGITS + 1);
    localparam int NGROUPS = (DIGITS + dbp_pkg::GROUP_DIGITS - 1) / dbp_pkg::GROUP_DIGITS;
    localparam int GW      = $clog2(NGROUPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BLOAD = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_YRD   = 4'd3;
    localparam logic [3:0] S_YGET  = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_CRD   = 4'd6;
    localparam logic [3:0] S_CWR   = 4'd7;
    localparam logic [3:0] S_PRD   = 4'd8;
    localparam logic [3:0] S_PWR   = 4'd9;
    localparam logic [3:0] S_SRD   = 4'd10;
    localparam logic [3:0] S_SCHK  = 4'd11;
    localparam logic [3:0] S_GRD   = 4'd12;
    localparam logic [3:0] S_GWR   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam logic [AW-1:0] I_LAST = AW'(DIGITS - 1);
    localparam logic [PW-1:0] K_LAST = PW'(2 * DIGITS - 1);

    logic [3:0]    r_state, n_state;
    logic [30:0]   r_b, n_b;
    logic [30:0]   r_e, n_e;
    logic [4:0]    r_bit, n_bit;
    logic          r_sq, n_sq;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [PW-1:0] r_k, n_k;
    logic [3:0]    r_carry, n_carry;
    logic [3:0]    r_y, n_y;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [GW-1:0] r_g, n_g;
    logic [3:0]    r_d, n_d;
    logic [63:0]   r_word, n_word;

    logic          acc_we, basd_we, prod_we;
    logic [AW-1:0] acc_waddr, acc_raddr, basd_addr;
    logic [3:0]    acc_wdata, basd_wdata, prod_wdata;
    logic [PW-1:0] prod_waddr, prod_raddr;
    logic [3:0]    acc_rd, basd_rd, prod_rd;

    logic [62:0]   bm;
    logic [30:0]   bq;
    logic [3:0]    brem;
    logic [7:0]    xy;
    logic [6:0]    t_row, t_cry;
    logic [3:0]    q_row, q_cry, r_row_d, r_cry_d;
    logic [3:0]    yv;
    logic [PW-1:0] ij;
    logic [GW+3:0] pos;
    logic          pos_ok;

    dbp_ram #(.W(4), .DEPTH(DIGITS)) u_acc (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rd)
    );

    dbp_ram #(.W(4), .DEPTH(DIGITS)) u_basd (
        .i_clk   (i_clk),
        .i_we    (basd_we),
        .i_waddr (basd_addr),
        .i_wdata (basd_wdata),
        .i_raddr (basd_addr),
        .o_rdata (basd_rd)
    );

    dbp_ram #(.W(4), .DEPTH(2 * DIGITS)) u_prod (
        .i_clk   (i_clk),
        .i_we    (prod_we),
        .i_waddr (prod_waddr),
        .i_wdata (prod_wdata),
        .i_raddr (prod_raddr),
        .o_rdata (prod_rd)
    );

    assign bm    = 63'(r_b) * 63'(dbp_pkg::RECIP10);
    assign bq    = 31'(bm >> 35);
    assign brem  = 4'(r_b - ((bq << 3) + (bq << 1)));

    assign xy      = 8'(acc_rd) * 8'(r_y);
    assign t_row   = 7'(xy) + 7'(r_carry) + 7'(prod_rd);
    assign q_row   = dbp_pkg::dec_div10(t_row);
    assign r_row_d = 4'(t_row - (7'({q_row, 3'b000}) + 7'({q_row, 1'b0})));
    assign t_cry   = 7'(r_carry) + 7'(prod_rd);
    assign q_cry   = dbp_pkg::dec_div10(t_cry);
    assign r_cry_d = 4'(t_cry - (7'({q_cry, 3'b000}) + 7'({q_cry, 1'b0})));

    assign yv     = r_sq ? acc_rd : basd_rd;
    assign ij     = PW'(r_i) + PW'(r_j);
    assign pos    = {r_g, r_d};
    assign pos_ok = pos < DIGITS;

    always_comb begin
        n_state = r_state;
        n_b     = r_b;
        n_e     = r_e;
        n_bit   = r_bit;
        n_sq    = r_sq;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_carry = r_carry;
        n_y     = r_y;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        n_g     = r_g;
        n_d     = r_d;
        n_word  = r_word;

        acc_we     = 1'b0;
        acc_waddr  = r_i;
        acc_wdata  = 4'd0;
        acc_raddr  = r_i;
        basd_we    = 1'b0;
        basd_addr  = r_i;
        basd_wdata = brem;
        prod_we    = 1'b0;
        prod_waddr = r_k;
        prod_wdata = 4'd0;
        prod_raddr = r_k;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_b     = i_base;
                    n_e     = i_exponent;
                    n_i     = '0;
                    n_ovf   = 1'b0;
                    n_state = S_BLOAD;
                end
            end
            S_BLOAD: begin
                basd_we   = 1'b1;
                acc_we    = 1'b1;
                acc_wdata = (r_i == '0) ? 4'd1 : 4'd0;
                n_b       = bq;
                if (r_i == I_LAST) begin
                    n_sq    = 1'b1;
                    n_bit   = 5'(dbp_pkg::EXP_BITS - 1);
                    n_k     = '0;
                    n_state = S_CLR;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_CLR: begin
                prod_we = 1'b1;
                if (r_k == K_LAST) begin
                    n_i     = '0;
                    n_state = S_YRD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_YRD: begin
                n_state = S_YGET;
            end
            S_YGET: begin
                if (yv == 4'd0) begin
                    if (r_i == I_LAST) begin
                        n_k     = '0;
                        n_state = S_PRD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_YRD;
                    end
                end else begin
                    n_y        = yv;
                    n_j        = '0;
                    n_carry    = 4'd0;
                    acc_raddr  = '0;
                    prod_raddr = PW'(r_i);
                    n_state    = S_ROW;
                end
            end
            S_ROW: begin
                prod_we    = 1'b1;
                prod_waddr = ij;
                prod_wdata = r_row_d;
                n_carry    = q_row;
                acc_raddr  = r_j + 1'b1;
                prod_raddr = ij + 1'b1;
                if (r_j == I_LAST) begin
                    n_k = PW'(r_i) + PW'(DIGITS);
                    if (q_row != 4'd0) begin
                        n_state = S_CRD;
                    end else if (r_i == I_LAST) begin
                        n_k     = '0;
                        n_state = S_PRD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_YRD;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_CRD: begin
                n_state = S_CWR;
            end
            S_CWR: begin
                prod_we    = 1'b1;
                prod_wdata = r_cry_d;
                n_carry    = q_cry;
                if (q_cry != 4'd0 && r_k != K_LAST) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_CRD;
                end else if (r_i == I_LAST) begin
                    n_k     = '0;
                    n_state = S_PRD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_YRD;
                end
            end
            S_PRD: begin
                n_state = S_PWR;
            end
            S_PWR: begin
                if (r_k < PW'(DIGITS)) begin
                    acc_we    = 1'b1;
                    acc_waddr = AW'(r_k);
                    acc_wdata = prod_rd;
                end else if (prod_rd != 4'd0) begin
                    n_ovf = 1'b1;
                end
                if (r_k == K_LAST) begin
                    n_k = '0;
                    if (r_sq && r_e[r_bit]) begin
                        n_sq    = 1'b0;
                        n_state = S_CLR;
                    end else if (r_bit == 5'd0) begin
                        n_i     = I_LAST;
                        n_state = S_SRD;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_sq    = 1'b1;
                        n_state = S_CLR;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_PRD;
                end
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (acc_rd != 4'd0 || r_i == '0) begin
                    n_cnt   = CW'(r_i) + 1'b1;
                    n_g     = GW'(r_i >> 4);
                    n_d     = 4'd15;
                    n_state = S_GRD;
                end else begin
                    n_i     = r_i - 1'b1;
                    n_state = S_SRD;
                end
            end
            S_GRD: begin
                acc_raddr = AW'(pos);
                n_state   = S_GWR;
            end
            S_GWR: begin
                n_word = {r_word[59:0], pos_ok ? acc_rd : 4'd0};
                if (r_d == 4'd0) begin
                    n_state = S_OUT;
                end else begin
                    n_d     = r_d - 1'b1;
                    n_state = S_GRD;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_g == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_g     = r_g - 1'b1;
                        n_d     = 4'd15;
                        n_state = S_GRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_b     <= n_b;
        r_e     <= n_e;
        r_bit   <= n_bit;
        r_sq    <= n_sq;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_carry <= n_carry;
        r_y     <= n_y;
        r_ovf   <= n_ovf;
        r_cnt   <= n_cnt;
        r_g     <= n_g;
        r_d     <= n_d;
        r_word  <= n_word;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digit_group = r_word;
    assign o_group_index = 3'(r_g);
    assign o_digit_count = 7'(r_cnt);
    assign o_overflow    = r_ovf;
    assign o_last_group  = (r_g == '0);

endmodule
